// ===== rtl/core/hermite_polynomial_evaluator_macros.svh =====
// Assertion macros shared by the Hermite polynomial evaluator RTL.
`ifndef HERMITE_POLYNOMIAL_EVALUATOR_MACROS_SVH
`define HERMITE_POLYNOMIAL_EVALUATOR_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define HPE_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define HPE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/hpe_pkg.sv =====
// Shared widths, command and status types, and saturation helper for the Hermite evaluator.
package hpe_pkg;

  localparam int X_W     = 16;
  localparam int RANK_W  = 4;
  localparam int VAL_W   = 64;
  localparam int COEF_W  = RANK_W + 1;
  localparam int MUL_A_W = X_W;
  localparam int PROD_W  = MUL_A_W + VAL_W;
  localparam int MAG_W   = 70;
  localparam int RND_SHIFT = 11;
  localparam int H1_SHIFT  = 5;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 72;

  localparam logic [RANK_W-1:0] MAX_RANK = 4'd15;

  localparam logic signed [VAL_W-1:0] VAL_ONE = 64'sd65536;
  localparam logic signed [VAL_W-1:0] VAL_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam logic signed [VAL_W-1:0] VAL_MIN = 64'sh8000_0000_0000_0000;
  localparam logic [MAG_W-1:0] MAG_LIMIT = 70'h0_8000_0000_0000_0000;
  localparam logic [PROD_W:0] RND_BIAS = 81'd1024;

  typedef enum logic [2:0] {
    OP_IDLE,
    OP_LOAD,
    OP_EMIT0,
    OP_EMIT1,
    OP_MULX,
    OP_MULC,
    OP_SATC,
    OP_SUB
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } dp_cmd_t;

  typedef struct packed {
    logic              out_free;
    logic              last;
    logic              ovf;
    logic [RANK_W-1:0] rank;
  } dp_sts_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] val;
    logic                    ovf;
  } sat_t;

  // Applies a sign to a magnitude and clamps the result to the signed 64-bit range.
  function automatic sat_t sat_signed(input logic neg, input logic [MAG_W-1:0] mag);
    sat_t r;
    r.ovf = 1'b0;
    if (!neg) begin
      if (mag >= MAG_LIMIT) begin
        r.val = VAL_MAX;
        r.ovf = 1'b1;
      end else begin
        r.val = mag[VAL_W-1:0];
      end
    end else begin
      if (mag > MAG_LIMIT) begin
        r.val = VAL_MIN;
        r.ovf = 1'b1;
      end else begin
        r.val = ~mag[VAL_W-1:0] + 64'd1;
      end
    end
    return r;
  endfunction

endpackage

// ===== rtl/core/hpe_ctrl.sv =====
// Sequencer that walks one item through its ranks and issues datapath commands.
module hpe_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  hpe_pkg::dp_sts_t sts_i,
  output hpe_pkg::dp_cmd_t cmd_o
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_H0   = 3'd1;
  localparam logic [2:0] ST_H1   = 3'd2;
  localparam logic [2:0] ST_MULX = 3'd3;
  localparam logic [2:0] ST_MULC = 3'd4;
  localparam logic [2:0] ST_SATC = 3'd5;
  localparam logic [2:0] ST_SUB  = 3'd6;

  logic [2:0] state_q, state_d;

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = hpe_pkg::OP_IDLE;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.op = hpe_pkg::OP_LOAD;
          state_d  = ST_H0;
        end
      end
      ST_H0: begin
        if (sts_i.out_free) begin
          cmd_o.op = hpe_pkg::OP_EMIT0;
          state_d  = sts_i.last ? ST_IDLE : ST_H1;
        end
      end
      ST_H1: begin
        if (sts_i.out_free) begin
          cmd_o.op = hpe_pkg::OP_EMIT1;
          state_d  = sts_i.last ? ST_IDLE : ST_MULX;
        end
      end
      ST_MULX: begin
        cmd_o.op = hpe_pkg::OP_MULX;
        state_d  = ST_MULC;
      end
      ST_MULC: begin
        cmd_o.op = hpe_pkg::OP_MULC;
        state_d  = ST_SATC;
      end
      ST_SATC: begin
        cmd_o.op = hpe_pkg::OP_SATC;
        state_d  = ST_SUB;
      end
      ST_SUB: begin
        if (sts_i.out_free) begin
          cmd_o.op = hpe_pkg::OP_SUB;
          state_d  = sts_i.last ? ST_IDLE : ST_MULX;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== rtl/core/hpe_dp.sv =====
// Recurrence datapath with the shared multiplier, saturation logic and output register.
module hpe_dp (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hpe_pkg::dp_cmd_t                    cmd_i,
  input  logic signed [hpe_pkg::X_W-1:0]      x_i,
  input  logic [hpe_pkg::RANK_W-1:0]          n_i,
  output hpe_pkg::dp_sts_t                    sts_o,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [hpe_pkg::RANK_W-1:0]          out_rank_o,
  output logic signed [hpe_pkg::VAL_W-1:0]    out_value_o,
  output logic                                out_ovf_o,
  output logic                                out_last_o
);

  logic signed [hpe_pkg::X_W-1:0]   x_q;
  logic [hpe_pkg::RANK_W-1:0]       n_q;
  logic [hpe_pkg::RANK_W-1:0]       k_q;
  logic                             ovf_q;
  logic signed [hpe_pkg::VAL_W-1:0] prev_q;
  logic signed [hpe_pkg::VAL_W-1:0] older_q;
  logic signed [hpe_pkg::VAL_W-1:0] t1_q;
  logic signed [hpe_pkg::VAL_W-1:0] t2_q;
  logic [hpe_pkg::PROD_W-1:0]       prod_q;
  logic                             prod_neg_q;
  logic                             out_valid_q;
  logic [hpe_pkg::RANK_W-1:0]       out_rank_q;
  logic signed [hpe_pkg::VAL_W-1:0] out_value_q;
  logic                             out_ovf_q;
  logic                             out_last_q;

  logic [hpe_pkg::X_W-1:0]          x_mag;
  logic [hpe_pkg::VAL_W-1:0]        prev_mag;
  logic [hpe_pkg::VAL_W-1:0]        older_mag;
  logic [hpe_pkg::COEF_W-1:0]       coef;
  logic [hpe_pkg::MUL_A_W-1:0]      mul_a;
  logic [hpe_pkg::VAL_W-1:0]        mul_b;
  logic [hpe_pkg::PROD_W-1:0]       mul_p;
  logic [hpe_pkg::PROD_W:0]         rnd;
  hpe_pkg::sat_t                    t1_s;
  hpe_pkg::sat_t                    t2_s;
  logic signed [hpe_pkg::VAL_W:0]   diff;
  logic signed [hpe_pkg::VAL_W-1:0] h1_val;
  logic signed [hpe_pkg::VAL_W-1:0] cur_val;
  logic                             cur_ovf;
  logic                             emit;

  assign x_mag     = x_q[hpe_pkg::X_W-1] ? (~x_q + 16'd1) : x_q;
  assign prev_mag  = prev_q[hpe_pkg::VAL_W-1] ? (~prev_q + 64'd1) : prev_q;
  assign older_mag = older_q[hpe_pkg::VAL_W-1] ? (~older_q + 64'd1) : older_q;
  assign coef      = {k_q - 4'd1, 1'b0};

  assign mul_a = (cmd_i.op == hpe_pkg::OP_MULC) ? {11'd0, coef} : x_mag;
  assign mul_b = (cmd_i.op == hpe_pkg::OP_MULC) ? older_mag : prev_mag;
  assign mul_p = {64'd0, mul_a} * {16'd0, mul_b};

  // The 2x product carries 28 fraction bits; the shift by 11 doubles it and rescales it.
  assign rnd  = {1'b0, prod_q} + hpe_pkg::RND_BIAS;
  assign t1_s = hpe_pkg::sat_signed(prod_neg_q, rnd[hpe_pkg::PROD_W:hpe_pkg::RND_SHIFT]);
  assign t2_s = hpe_pkg::sat_signed(prod_neg_q, prod_q[hpe_pkg::MAG_W-1:0]);
  assign diff = {t1_q[hpe_pkg::VAL_W-1], t1_q} - {t2_q[hpe_pkg::VAL_W-1], t2_q};
  assign h1_val = {{43{x_q[hpe_pkg::X_W-1]}}, x_q, 5'd0};

  assign emit = (cmd_i.op == hpe_pkg::OP_EMIT0) || (cmd_i.op == hpe_pkg::OP_EMIT1) ||
                (cmd_i.op == hpe_pkg::OP_SUB);

  always_comb begin
    cur_val = hpe_pkg::VAL_ONE;
    cur_ovf = ovf_q;
    case (cmd_i.op)
      hpe_pkg::OP_EMIT1: begin
        cur_val = h1_val;
      end
      hpe_pkg::OP_SUB: begin
        if (diff[hpe_pkg::VAL_W] != diff[hpe_pkg::VAL_W-1]) begin
          cur_val = diff[hpe_pkg::VAL_W] ? hpe_pkg::VAL_MIN : hpe_pkg::VAL_MAX;
          cur_ovf = 1'b1;
        end else begin
          cur_val = diff[hpe_pkg::VAL_W-1:0];
        end
      end
      default: begin
        cur_val = hpe_pkg::VAL_ONE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      k_q         <= '0;
      ovf_q       <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (cmd_i.op)
        hpe_pkg::OP_LOAD: begin
          k_q   <= '0;
          ovf_q <= 1'b0;
        end
        hpe_pkg::OP_EMIT0, hpe_pkg::OP_EMIT1, hpe_pkg::OP_SUB: begin
          k_q   <= k_q + 4'd1;
          ovf_q <= cur_ovf;
        end
        hpe_pkg::OP_MULC: begin
          ovf_q <= ovf_q | t1_s.ovf;
        end
        hpe_pkg::OP_SATC: begin
          ovf_q <= ovf_q | t2_s.ovf;
        end
        default: begin
          ovf_q <= ovf_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      hpe_pkg::OP_LOAD: begin
        x_q <= x_i;
        n_q <= (n_i > hpe_pkg::MAX_RANK) ? hpe_pkg::MAX_RANK : n_i;
      end
      hpe_pkg::OP_EMIT0, hpe_pkg::OP_EMIT1, hpe_pkg::OP_SUB: begin
        out_rank_q  <= k_q;
        out_value_q <= cur_val;
        out_ovf_q   <= cur_ovf;
        out_last_q  <= (k_q == n_q);
        older_q     <= prev_q;
        prev_q      <= cur_val;
      end
      hpe_pkg::OP_MULX: begin
        prod_q     <= mul_p;
        prod_neg_q <= x_q[hpe_pkg::X_W-1] ^ prev_q[hpe_pkg::VAL_W-1];
      end
      hpe_pkg::OP_MULC: begin
        t1_q       <= t1_s.val;
        prod_q     <= mul_p;
        prod_neg_q <= older_q[hpe_pkg::VAL_W-1];
      end
      hpe_pkg::OP_SATC: begin
        t2_q <= t2_s.val;
      end
      default: begin
        prod_q <= prod_q;
      end
    endcase
  end

  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.last     = (k_q == n_q);
  assign sts_o.ovf      = ovf_q;
  assign sts_o.rank     = k_q;

  assign out_valid_o = out_valid_q;
  assign out_rank_o  = out_rank_q;
  assign out_value_o = out_value_q;
  assign out_ovf_o   = out_ovf_q;
  assign out_last_o  = out_last_q;

endmodule

// ===== rtl/core/hermite_polynomial_evaluator.sv =====
// Top level of the physicists' Hermite polynomial evaluator.
// Each input transaction carries a sample x (signed Q4.12) and a highest rank n; the block
// returns one output transaction per rank k = 0..n with H_k(x) in signed Q47.16, saturated,
// a sticky overflow flag in tuser and tlast on rank n. One item is worked at a time: after
// the input is taken, ranks 0 and 1 are emitted directly and every higher rank passes
// through the MULX, MULC, SATC and SUB steps: the single 16 x 64 bit multiplier forms
// 2x*H(k-1) and then 2(k-1)*H(k-2), followed by rounding, saturation and the final
// subtraction. Every emit waits while the output is stalled. The next item is taken while
// the last result of the previous one still waits in the output register.
`include "hermite_polynomial_evaluator_macros.svh"

module hermite_polynomial_evaluator (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // Fields from bit 0: x_sample[15:0], max_rank[19:16], zero fill.
  input  logic [hpe_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // Fields from bit 0: rank[3:0], poly_value[67:4], zero fill.
  output logic [hpe_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,
  // Fields from bit 0: overflow.
  output logic                               m_axis_tuser_o,
  output logic                               m_axis_tlast_o
);

  hpe_pkg::dp_cmd_t                 cmd;
  hpe_pkg::dp_sts_t                 sts;
  logic [hpe_pkg::RANK_W-1:0]       out_rank;
  logic signed [hpe_pkg::VAL_W-1:0] out_value;
  logic                             in_xfer;

  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  hpe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  hpe_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .x_i         (s_axis_tdata_i[15:0]),
    .n_i         (s_axis_tdata_i[19:16]),
    .sts_o       (sts),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .out_rank_o  (out_rank),
    .out_value_o (out_value),
    .out_ovf_o   (m_axis_tuser_o),
    .out_last_o  (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'd0, out_value, out_rank};

  `HPE_ASSERT_NEXT(a_load_clears, clk_i, rst_ni, in_xfer, (sts.rank == '0) && !sts.ovf, "Item start did not clear rank and overflow.")
  `HPE_ASSERT_NEXT(a_ovf_sticky, clk_i, rst_ni, sts.ovf && !in_xfer, sts.ovf, "Overflow flag dropped within an item.")
  `HPE_ASSERT_NOW(a_rank0_clean, clk_i, rst_ni, m_axis_tvalid_o && (m_axis_tdata_o[3:0] == '0), !m_axis_tuser_o, "Rank zero result reports overflow.")

endmodule
